@@ rtl/piad_pkg.sv @@
// Shared types and codes for the positional insert/delete word list.
package piad_pkg;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_INSERT  = 2'd1;
    localparam logic [1:0] CMD_DELETE  = 2'd2;
    localparam logic [1:0] CMD_DISPLAY = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [4:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [4:0]         index;
        logic [4:0]         entries;
        logic               last;
    } rsp_t;

endpackage

@@ rtl/piad_ram.sv @@
// Word store: one write port and one read port with registered read data.
module piad_ram #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [31:0]              wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [31:0]              rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // The read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/piad_out_fifo.sv @@
// Two-entry result buffer between the sequencer and the result channel.
module piad_out_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  piad_pkg::rsp_t push_item,
    output logic          full,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output piad_pkg::rsp_t rsp
);
    import piad_pkg::*;

    rsp_t       buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign rsp_valid = (count_reg != 2'd0);
    assign rsp       = buf_reg[rd_ptr_reg];
    assign pop       = rsp_valid && !rsp_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/positional_insert_delete_array_unit.sv @@
// Top level: command sequencer over the word store and the result buffer.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   piad_pkg::req_t (cmd, position, value)
//   rsp      out        rsp_valid/rsp_stall   piad_pkg::rsp_t (status..last)
//
// Clear, rejected commands and an append are handled directly from the idle state.
// An insert that moves entries shifts the words above the position up, and a delete
// shifts them down, one entry per cycle through the store's read and write ports.
// Display sends one item per cycle for each stored word while the result buffer has room.
// Reset clears the count; the store itself is not cleared. A stalled result channel holds
// the sequencer once the two-entry result buffer is full; requests are taken only while
// the sequencer is idle.
module positional_insert_delete_array_unit #(
    parameter int CAPACITY = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  piad_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output piad_pkg::rsp_t rsp
);
    import piad_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UP   = 5'b00010,
        S_FIN  = 5'b00100,
        S_DN   = 5'b01000,
        S_DISP = 5'b10000
    } state_t;

    state_t       state_reg, state_next;
    logic [CW-1:0] used_reg, used_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic          rd_more_reg, rd_more_next;
    logic          pend_reg, pend_next;
    logic          cap_reg, cap_next;
    logic [31:0]   val_reg, val_next;
    logic [31:0]   gone_reg, gone_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          push, fifo_full, accept;
    rsp_t          push_item;
    logic [XW-1:0] pos_x, used_x;
    logic [AW-1:0] top_idx;

    assign req_stall = !((state_reg == S_IDLE) && !fifo_full);
    assign accept    = req_valid && !req_stall;
    assign pos_x     = XW'(req.position);
    assign used_x    = XW'(used_reg);
    assign top_idx   = AW'(used_reg - 1'b1);

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        ptr_next     = ptr_reg;
        pos_next     = pos_reg;
        wa_next      = wa_reg;
        rd_more_next = rd_more_reg;
        pend_next    = 1'b0;
        cap_next     = cap_reg;
        val_next     = val_reg;
        gone_next    = gone_reg;
        ram_we       = 1'b0;
        ram_waddr    = wa_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = ptr_reg;
        push         = 1'b0;
        push_item    = '0;
        push_item.entries = 5'(used_reg);
        push_item.last    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        CMD_CLEAR:
                        begin
                            used_next         = '0;
                            push              = 1'b1;
                            push_item.status  = ST_OK;
                            push_item.entries = 5'd0;
                        end
                        CMD_INSERT:
                        begin
                            push = 1'b1;
                            if (used_reg >= CW'(CAPACITY))
                            begin
                                push_item.status = ST_FULL;
                            end
                            else if (pos_x > used_x)
                            begin
                                push_item.status = ST_BADPOS;
                            end
                            else if (pos_x == used_x)
                            begin
                                // Append: nothing above to move.
                                ram_we            = 1'b1;
                                ram_waddr         = AW'(req.position);
                                ram_wdata         = req.value;
                                used_next         = used_reg + 1'b1;
                                push_item.status  = ST_OK;
                                push_item.data    = req.value;
                                push_item.index   = req.position;
                                push_item.entries = 5'(used_next);
                            end
                            else
                            begin
                                push         = 1'b0;
                                pos_next     = AW'(req.position);
                                val_next     = req.value;
                                ptr_next     = top_idx;
                                rd_more_next = 1'b1;
                                state_next   = S_UP;
                            end
                        end
                        CMD_DELETE:
                        begin
                            push = 1'b1;
                            if (used_reg == '0)
                            begin
                                push_item.status = ST_EMPTY;
                            end
                            else if (pos_x >= used_x)
                            begin
                                push_item.status = ST_BADPOS;
                            end
                            else
                            begin
                                push         = 1'b0;
                                pos_next     = AW'(req.position);
                                ptr_next     = AW'(req.position);
                                rd_more_next = 1'b1;
                                state_next   = S_DN;
                            end
                        end
                        default:
                        begin
                            if (used_reg == '0)
                            begin
                                push             = 1'b1;
                                push_item.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                ptr_next   = '0;
                                state_next = S_DISP;
                            end
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // Read entry k while the entry read last cycle lands at k + 2.
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (rd_more_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    wa_next   = ptr_reg + 1'b1;
                    if (ptr_reg == pos_reg)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                end
                else if (pend_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                ram_we            = 1'b1;
                ram_waddr         = pos_reg;
                ram_wdata         = val_reg;
                used_next         = used_reg + 1'b1;
                push              = 1'b1;
                push_item.status  = ST_OK;
                push_item.data    = val_reg;
                push_item.index   = 5'(pos_reg);
                push_item.entries = 5'(used_next);
                state_next        = S_IDLE;
            end
            S_DN:
            begin
                // The first word read is the removed one; later reads move down.
                if (pend_reg)
                begin
                    if (cap_reg)
                    begin
                        gone_next = ram_rdata;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
                if (rd_more_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    cap_next  = (ptr_reg == pos_reg);
                    wa_next   = ptr_reg - 1'b1;
                    if (ptr_reg == top_idx)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                else if (pend_reg)
                begin
                    used_next         = used_reg - 1'b1;
                    push              = 1'b1;
                    push_item.status  = ST_OK;
                    push_item.data    = cap_reg ? ram_rdata : gone_reg;
                    push_item.index   = 5'(pos_reg);
                    push_item.entries = 5'(used_next);
                    state_next        = S_IDLE;
                end
            end
            S_DISP:
            begin
                if (!fifo_full)
                begin
                    push             = 1'b1;
                    push_item.status = ST_OK;
                    push_item.data   = ram_rdata;
                    push_item.index  = 5'(ptr_reg);
                    push_item.last   = (ptr_reg == top_idx);
                    if (ptr_reg == top_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg + 1'b1;
                        ptr_next  = ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            rd_more_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            rd_more_reg <= rd_more_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        pos_reg  <= pos_next;
        wa_reg   <= wa_next;
        cap_reg  <= cap_next;
        val_reg  <= val_next;
        gone_reg <= gone_next;
    end

    piad_ram #(
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    piad_out_fifo u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .full     (fifo_full),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule

@@ tb/sv/piad_checker.sv @@
// Checker for the word list: tracks the list from accepted requests and compares every result item.
module piad_checker
    import piad_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_stall,
    input  req_t       req,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  rsp_t       rsp,
    input  logic       wrap_up,
    output int         failures,
    output int         pending,
    output logic [4:0] stored
);

    logic signed [31:0] word_store [CAPACITY];
    logic [4:0]         word_count;
    rsp_t               awaited_rsp [$];

    int cmd_seen [4] = '{default: 0};
    int results_checked = 0;
    int full_seen = 0;
    int badpos_seen = 0;
    int empty_seen = 0;
    int peak_count = 0;
    bit summarized = 1'b0;

    function automatic void await_rsp(logic [1:0] status, logic signed [31:0] data,
                                      logic [4:0] index, logic last);
        rsp_t r;
        r.status  = status;
        r.data    = data;
        r.index   = index;
        r.entries = word_count;
        r.last    = last;
        awaited_rsp.push_back(r);
        case (status)
            ST_FULL:   full_seen++;
            ST_BADPOS: badpos_seen++;
            ST_EMPTY:  empty_seen++;
            default:   ;
        endcase
    endfunction

    // Applies one command to the tracked list and queues the result items it causes.
    function automatic void apply_list_cmd(req_t item);
        int pos;
        logic signed [31:0] gone;
        pos = item.position;
        cmd_seen[item.cmd]++;
        case (item.cmd)
            CMD_CLEAR:
            begin
                word_count = '0;
                await_rsp(ST_OK, '0, '0, 1'b1);
            end
            CMD_INSERT:
            begin
                // A full list is rejected before the position is looked at.
                if (word_count >= CAPACITY)
                    await_rsp(ST_FULL, '0, '0, 1'b1);
                else if (pos > word_count)
                    await_rsp(ST_BADPOS, '0, '0, 1'b1);
                else
                begin
                    for (int i = word_count; i > pos; i--)
                        word_store[i] = word_store[i - 1];
                    word_store[pos] = item.value;
                    word_count = word_count + 1'b1;
                    await_rsp(ST_OK, item.value, item.position, 1'b1);
                end
            end
            CMD_DELETE:
            begin
                if (word_count == 0)
                    await_rsp(ST_EMPTY, '0, '0, 1'b1);
                else if (pos >= word_count)
                    await_rsp(ST_BADPOS, '0, '0, 1'b1);
                else
                begin
                    gone = word_store[pos];
                    for (int i = pos; i + 1 < word_count; i++)
                        word_store[i] = word_store[i + 1];
                    word_count = word_count - 1'b1;
                    await_rsp(ST_OK, gone, item.position, 1'b1);
                end
            end
            CMD_DISPLAY:
            begin
                if (word_count == 0)
                    await_rsp(ST_EMPTY, '0, '0, 1'b1);
                else
                    for (int i = 0; i < word_count; i++)
                        await_rsp(ST_OK, word_store[i], i[4:0], i + 1 == word_count);
            end
        endcase
        if (word_count > peak_count)
            peak_count = word_count;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            word_count = '0;
            awaited_rsp.delete();
            failures = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                apply_list_cmd(req);
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $error("result item arrived with nothing expected (status %0d, data %0d)",
                           rsp.status, rsp.data);
                    failures++;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    results_checked++;
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        failures++;
                    end
                    if (rsp.data !== want.data)
                    begin
                        $error("data: expected %0d, got %0d", want.data, rsp.data);
                        failures++;
                    end
                    if (rsp.index !== want.index)
                    begin
                        $error("index: expected %0d, got %0d", want.index, rsp.index);
                        failures++;
                    end
                    if (rsp.entries !== want.entries)
                    begin
                        $error("entries: expected %0d, got %0d", want.entries, rsp.entries);
                        failures++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, rsp.last);
                        failures++;
                    end
                end
            end
            if (wrap_up && !summarized)
            begin
                summarized = 1'b1;
                if (awaited_rsp.size() != 0)
                begin
                    $error("%0d expected result items never arrived", awaited_rsp.size());
                    failures++;
                end
                $display("Covered %0d commands (%0d clear, %0d insert, %0d delete, %0d display), %0d result items checked.",
                         cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3], cmd_seen[CMD_CLEAR],
                         cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE], cmd_seen[CMD_DISPLAY],
                         results_checked);
                $display("Rejections seen: %0d full, %0d bad position, %0d empty; list reached %0d words.",
                         full_seen, badpos_seen, empty_seen, peak_count);
            end
        end
        pending = awaited_rsp.size();
        stored  = word_count;
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: clock, reset, request stimulus, result stalls and the final verdict.
module tb;
    import piad_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int RANDOM_ITEMS  = 420;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_t;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_t       rsp;
    logic       wrap_up;
    int         failures;
    int         pending;
    logic [4:0] stored;
    int         cycle_count;
    bit         burst_mode;

    positional_insert_delete_array_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    piad_checker #(
        .CAPACITY (CAPACITY)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .wrap_up   (wrap_up),
        .failures  (failures),
        .pending   (pending),
        .stored    (stored)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic req_t list_cmd(logic [1:0] cmd, int pos, logic [31:0] val);
        req_t item;
        item.cmd      = cmd;
        item.position = pos[4:0];
        item.value    = val;
        return item;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 24))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 8);
        return $urandom_range(12, 30);
    endfunction

    // Mostly legal positions for the current list length, with some anywhere in range.
    function automatic req_t pick_list_cmd(mix_t mix, int count);
        int r;
        int ins_lim;
        int del_lim;
        int disp_lim;
        int pos;
        logic [1:0] cmd;
        case (mix)
            MIX_GROW:   begin ins_lim = 70; del_lim = 82; disp_lim = 98; end
            MIX_SHRINK: begin ins_lim = 15; del_lim = 75; disp_lim = 96; end
            default:    begin ins_lim = 42; del_lim = 80; disp_lim = 97; end
        endcase
        r = $urandom_range(0, 99);
        if (r < ins_lim)
            cmd = CMD_INSERT;
        else if (r < del_lim)
            cmd = CMD_DELETE;
        else if (r < disp_lim)
            cmd = CMD_DISPLAY;
        else
            cmd = CMD_CLEAR;
        if ($urandom_range(0, 99) >= 85)
            pos = $urandom_range(0, 16);
        else if (cmd == CMD_DELETE)
            pos = (count == 0) ? 0 : $urandom_range(0, count - 1);
        else
            pos = $urandom_range(0, count);
        return list_cmd(cmd, pos, pick_value());
    endfunction

    task automatic offer(input req_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    // Result side: short stalls most of the time, a few long ones, and stretches with none.
    initial
    begin : rsp_stall_pattern
        int quiet;
        int held;
        int r;
        rsp_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            quiet = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 4);
            r = $urandom_range(0, 99);
            if (r < 70)
                held = $urandom_range(1, 2);
            else if (r < 95)
                held = $urandom_range(3, 6);
            else
                held = $urandom_range(10, 20);
            rsp_stall <= 1'b0;
            repeat (quiet) @(negedge clk);
            rsp_stall <= 1'b1;
            repeat (held) @(negedge clk);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        mix_t mix;
        int   mix_left;
        req_valid  = 1'b0;
        req        = '0;
        wrap_up    = 1'b0;
        burst_mode = 1'b0;
        rst_n      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty list: display, delete and an insert past the end are all refused.
        offer(list_cmd(CMD_DISPLAY, 0, 32'h0));
        offer(list_cmd(CMD_DELETE, 0, 32'h0));
        offer(list_cmd(CMD_INSERT, 1, 32'h1234_5678));
        // Build a short list with front, append and middle inserts of extreme words.
        offer(list_cmd(CMD_INSERT, 0, 32'h7FFF_FFFF));
        offer(list_cmd(CMD_INSERT, 0, 32'h8000_0000));
        offer(list_cmd(CMD_INSERT, 2, 32'hFFFF_FFFF));
        offer(list_cmd(CMD_INSERT, 1, 32'h0000_0000));
        offer(list_cmd(CMD_INSERT, 5, 32'h5555_AAAA));
        offer(list_cmd(CMD_DISPLAY, 16, 32'hFFFF_FFFF));
        // Deletes at the count and at position 16 are refused.
        offer(list_cmd(CMD_DELETE, 4, 32'h0));
        offer(list_cmd(CMD_DELETE, 16, 32'hFFFF_FFFF));
        offer(list_cmd(CMD_DELETE, 1, 32'h0));
        offer(list_cmd(CMD_DELETE, 0, 32'h0));
        offer(list_cmd(CMD_DELETE, 1, 32'h0));
        offer(list_cmd(CMD_DISPLAY, 0, 32'h0));
        offer(list_cmd(CMD_CLEAR, 16, 32'hFFFF_FFFF));
        offer(list_cmd(CMD_DISPLAY, 0, 32'h0));
        offer(list_cmd(CMD_INSERT, 0, 32'hA5A5_5A5A));
        offer(list_cmd(CMD_CLEAR, 0, 32'h0));

        // Start by growing so the list fills early, then wander between mixes.
        mix      = MIX_GROW;
        mix_left = 40;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (mix_left == 0)
            begin
                mix        = mix_t'($urandom_range(0, 2));
                mix_left   = $urandom_range(25, 50);
                burst_mode = ($urandom_range(0, 3) == 0);
            end
            mix_left--;
            offer(pick_list_cmd(mix, stored));
        end
        req_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        wrap_up <= 1'b1;
        @(negedge clk);
        @(negedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/piad_pkg.sv
rtl/piad_ram.sv
rtl/piad_out_fifo.sv
rtl/positional_insert_delete_array_unit.sv
tb/sv/piad_checker.sv
tb/sv/tb.sv
